### rtl/ttw_pkg.sv
package ttw_pkg;

    // Default grid size.
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // Field widths of the request and response items.
    localparam int KIND_W     = 2;
    localparam int CODE_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int INDEX_W    = 11;
    localparam int CELL_W     = 16;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;

    // Character and color codes.
    localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CODE_W-1:0]  SPACE_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE     = 2'd0,
        KIND_RAINBOW   = 2'd1,
        KIND_SET_COLOR = 2'd2,
        KIND_READ      = 2'd3
    } kind_t;

    // A classified request, as it waits in the queue between front and back.
    typedef struct packed {
        kind_t               kind;
        logic                newline;
        logic [CODE_W-1:0]   char_code;
        logic [COLOR_W-1:0]  new_color;
        logic [INDEX_W-1:0]  cell_index;
    } op_t;

    // Status of the back end as seen by the front end.
    typedef struct packed {
        logic clearing;
    } back_status_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_CLEAR
    } back_state_t;

endpackage

### rtl/ttw_req_if.sv
interface ttw_req_if;
    import ttw_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CODE_W-1:0]  char_code;
    logic [COLOR_W-1:0] new_color;
    logic [INDEX_W-1:0] cell_index;

    modport source (output valid, kind, char_code, new_color, cell_index, input ready);
    modport sink (input valid, kind, char_code, new_color, cell_index, output ready);

endinterface

### rtl/ttw_rsp_if.sv
interface ttw_rsp_if;
    import ttw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [COLOR_W-1:0]   color_now;
    logic                 scrolled;

    modport source (output valid, cell_value, cursor_row, cursor_col, color_now, scrolled,
                    input ready);
    modport sink (input valid, cell_value, cursor_row, cursor_col, color_now, scrolled,
                  output ready);

endinterface

### rtl/text_mode_terminal_writer_unit.sv
// Text-mode terminal writer over a ROWS x COLUMNS grid of 16-bit cells
// (character in the low byte, color in the high byte).
// Channels: req carries one item (kind, char_code, new_color, cell_index) and
// rsp returns exactly one result per item (cell_value, cursor_row, cursor_col,
// color_now, scrolled), in order, with valid/ready handshakes on both sides.
// A two-entry queue parts the front end from the sequencer that owns the cell
// memory, so new items are taken while a result waits on rsp.
// A write or color item, or a read past the end of the screen, passes through
// the queue and the result register; a read of a cell on the screen also waits
// in the read wait state for the registered memory read port.
// One write or color item per cycle while rsp keeps up and no scroll runs.
// A newline or a wrap on the last row scrolls the screen: the memory copies
// one cell per cycle, each row one row up, then clears the last row, and
// input stalls once the queue fills.
// Reset: the cursor goes to the top left, the color to grey on black, and a
// clear pass writes a grey space to every cell, one per cycle, during which
// req.ready stays low.
// When rsp stalls, the result holds, the queue fills and req.ready drops.
module text_mode_terminal_writer_unit #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    ttw_req_if.sink   req,
    ttw_rsp_if.source rsp
);
    import ttw_pkg::*;

    back_status_t status;
    logic         op_valid;
    logic         op_pop;
    op_t          op;

    ttw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .status   (status),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop)
    );

    ttw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop),
        .status   (status),
        .rsp      (rsp)
    );

endmodule

### rtl/ttw_ram.sv
module ttw_ram #(
    parameter int WIDTH = ttw_pkg::CELL_W,
    parameter int DEPTH = ttw_pkg::COLUMNS_DEFAULT * ttw_pkg::ROWS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ttw_front.sv
module ttw_front (
    input  logic                  clk,
    input  logic                  rst_n,
    ttw_req_if.sink               req,
    input  ttw_pkg::back_status_t status,
    output logic                  op_valid,
    output ttw_pkg::op_t          op,
    input  logic                  op_pop
);
    import ttw_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    op_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    op_t              op_in;
    logic             push;
    logic             pop;

    // Accept while the queue has room and the screen clear after reset is done.
    assign req.ready = (count_reg != CNT_W'(QUEUE_DEPTH)) && !status.clearing;
    assign push      = req.valid && req.ready;
    assign op_valid  = (count_reg != '0);
    assign pop       = op_pop && op_valid;
    assign op        = queue_reg[rd_ptr_reg];

    // Classify the incoming item.
    always_comb
    begin
        op_in.kind       = kind_t'(req.kind);
        op_in.newline    = (req.char_code == NEWLINE_CODE);
        op_in.char_code  = req.char_code;
        op_in.new_color  = req.new_color;
        op_in.cell_index = req.cell_index;
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= op_in;
        end
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/ttw_back.sv
module ttw_back #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    input  ttw_pkg::op_t          op,
    output logic                  op_pop,
    output ttw_pkg::back_status_t status,
    ttw_rsp_if.source             rsp
);
    import ttw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int SCAN_W     = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
    localparam logic [SCAN_W-1:0] LAST_CELL     = SCAN_W'(CELL_COUNT - 1);
    localparam logic [SCAN_W-1:0] LAST_ROW_BASE = SCAN_W'(CELL_COUNT - COLUMNS);
    localparam logic [SCAN_W-1:0] ROW_STRIDE    = SCAN_W'(COLUMNS);

    back_state_t        state_reg, state_next;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [COLOR_W-1:0] attr_reg, attr_next;
    logic               copy_valid_reg, copy_valid_next;
    logic [ADDR_W-1:0]  copy_dst_reg, copy_dst_next;
    logic               res_valid_reg, res_valid_next;
    logic [CELL_W-1:0]  res_value_reg, res_value_next;
    logic               res_scrolled_reg, res_scrolled_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    logic               slot_free;
    logic               take;
    logic               is_char;
    logic               at_row_end;
    logic               need_scroll;
    logic               read_hit;
    logic [COLOR_W-1:0] color_eff;
    logic [ADDR_W-1:0]  cur_addr;

    ttw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode of the item at the head of the queue.
    always_comb
    begin
        slot_free   = !res_valid_reg || rsp.ready;
        take        = (state_reg == ST_IDLE) && op_valid && slot_free;
        is_char     = (op.kind inside {KIND_WRITE, KIND_RAINBOW});
        at_row_end  = op.newline || (col_reg == LAST_COL);
        need_scroll = is_char && at_row_end && (row_reg == LAST_ROW);
        read_hit    = (op.kind == KIND_READ) && (int'(op.cell_index) < CELL_COUNT);
        color_eff   = attr_reg;
        if (op.kind == KIND_RAINBOW)
        begin
            color_eff = {attr_reg[7:4] + 4'd1, attr_reg[3:0] + 4'd1};
        end
        cur_addr = ADDR_W'(int'(row_reg) * COLUMNS + int'(col_reg));
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (scan_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    if (need_scroll)
                    begin
                        state_next = ST_SCROLL;
                    end
                    else if (read_hit)
                    begin
                        state_next = ST_READ_WAIT;
                    end
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                if (scan_reg == LAST_CELL)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (!copy_valid_reg && (scan_reg == LAST_CELL))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Datapath, memory port and result control per state.
    always_comb
    begin
        scan_next         = scan_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        attr_next         = attr_reg;
        copy_valid_next   = 1'b0;
        copy_dst_next     = copy_dst_reg;
        res_valid_next    = res_valid_reg && !rsp.ready;
        res_value_next    = res_value_reg;
        res_scrolled_next = res_scrolled_reg;
        ram_we            = 1'b0;
        ram_waddr         = cur_addr;
        ram_wdata         = {color_eff, op.char_code};
        ram_raddr         = ADDR_W'(op.cell_index);
        op_pop            = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                // Clear pass after reset, one cell per cycle.
                ram_we    = 1'b1;
                ram_waddr = scan_reg[ADDR_W-1:0];
                ram_wdata = {RESET_COLOR, SPACE_CODE};
                scan_next = scan_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    op_pop = 1'b1;
                    case (op.kind)
                        KIND_WRITE, KIND_RAINBOW:
                        begin
                            attr_next = color_eff;
                            ram_we    = !op.newline;
                            if (at_row_end)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    scan_next = ROW_STRIDE;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                            if (!need_scroll)
                            begin
                                res_valid_next    = 1'b1;
                                res_value_next    = '0;
                                res_scrolled_next = 1'b0;
                            end
                        end
                        KIND_SET_COLOR:
                        begin
                            attr_next         = op.new_color;
                            res_valid_next    = 1'b1;
                            res_value_next    = '0;
                            res_scrolled_next = 1'b0;
                        end
                        KIND_READ:
                        begin
                            // An index beyond the screen reads as zero at once.
                            if (!read_hit)
                            begin
                                res_valid_next    = 1'b1;
                                res_value_next    = '0;
                                res_scrolled_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            res_valid_next = res_valid_reg && !rsp.ready;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                res_valid_next    = 1'b1;
                res_value_next    = ram_rdata;
                res_scrolled_next = 1'b0;
            end
            ST_SCROLL:
            begin
                // Read one row ahead and write the cell back one row up once the registered read data arrives.
                ram_raddr       = scan_reg[ADDR_W-1:0];
                copy_valid_next = 1'b1;
                copy_dst_next   = ADDR_W'(scan_reg - ROW_STRIDE);
                scan_next       = (scan_reg == LAST_CELL) ? LAST_ROW_BASE : scan_reg + 1'b1;
                if (copy_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = copy_dst_reg;
                    ram_wdata = ram_rdata;
                end
            end
            ST_CLEAR:
            begin
                if (copy_valid_reg)
                begin
                    // The last copied cell takes the write port first.
                    ram_we    = 1'b1;
                    ram_waddr = copy_dst_reg;
                    ram_wdata = ram_rdata;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = scan_reg[ADDR_W-1:0];
                    ram_wdata = {attr_reg, SPACE_CODE};
                    if (scan_reg == LAST_CELL)
                    begin
                        res_valid_next    = 1'b1;
                        res_value_next    = '0;
                        res_scrolled_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Response and status. The cursor and color cannot change while a result waits.
    assign rsp.valid      = res_valid_reg;
    assign rsp.cell_value = res_value_reg;
    assign rsp.scrolled   = res_scrolled_reg;
    assign rsp.cursor_row = ROW_OUT_W'(row_reg);
    assign rsp.cursor_col = COL_OUT_W'(col_reg);
    assign rsp.color_now  = attr_reg;
    assign status.clearing = (state_reg == ST_INIT);

    // Payload registers.
    always_ff @(posedge clk)
    begin
        copy_dst_reg     <= copy_dst_next;
        res_value_reg    <= res_value_next;
        res_scrolled_reg <= res_scrolled_next;
    end

    // Control and terminal state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            scan_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            attr_reg       <= RESET_COLOR;
            copy_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            attr_reg       <= attr_next;
            copy_valid_reg <= copy_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

`ifndef SYNTH
    // The cursor never leaves the grid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= LAST_ROW) && (col_reg <= LAST_COL))
        else $error("cursor outside the grid");

    // Every cell write lands inside the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (int'(ram_waddr) < CELL_COUNT))
        else $error("cell write beyond the screen");

    // Read data arrives only when the result register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ_WAIT) |-> !res_valid_reg)
        else $error("read result would overwrite a pending result");

    // Nothing leaves the queue during the clear pass after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !op_pop)
        else $error("item taken during the clear pass");
`endif

endmodule

### bench/text_mode_terminal_writer_unit_tb.sv
module text_mode_terminal_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttw_pkg::*;

    localparam int GRID_COLS  = COLUMNS_DEFAULT;
    localparam int GRID_ROWS  = ROWS_DEFAULT;
    localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
    localparam int INDEX_MAX  = (1 << INDEX_W) - 1;

    // One result item as the terminal reports it.
    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [COLOR_W-1:0]   color_now;
        logic                 scrolled;
    } term_status_t;

    logic clk = 1'b0;
    logic rst_n;

    ttw_req_if req_ch();
    ttw_rsp_if rsp_ch();

    text_mode_terminal_writer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the screen, cursor and color.
    logic [CELL_W-1:0]  shadow_cells [GRID_CELLS];
    int unsigned        shadow_row;
    int unsigned        shadow_col;
    logic [COLOR_W-1:0] shadow_color;

    term_status_t pending_status[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    always #6 clk = ~clk;

    // Screen model.

    function automatic void reset_shadow();
        for (int i = 0; i < GRID_CELLS; i++)
            shadow_cells[i] = {RESET_COLOR, SPACE_CODE};
        shadow_row   = 0;
        shadow_col   = 0;
        shadow_color = RESET_COLOR;
    endfunction

    // Moves the cursor to the next row; scrolls on the last row and reports it.
    function automatic logic shadow_next_row();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= GRID_ROWS) begin
            shadow_row = GRID_ROWS - 1;
            for (int i = 0; i < GRID_CELLS - GRID_COLS; i++)
                shadow_cells[i] = shadow_cells[i + GRID_COLS];
            for (int i = GRID_CELLS - GRID_COLS; i < GRID_CELLS; i++)
                shadow_cells[i] = {shadow_color, SPACE_CODE};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic shadow_put_char(input logic [CODE_W-1:0] code);
        if (code == NEWLINE_CODE)
            return shadow_next_row();
        shadow_cells[shadow_row * GRID_COLS + shadow_col] = {shadow_color, code};
        shadow_col++;
        if (shadow_col >= GRID_COLS)
            return shadow_next_row();
        return 1'b0;
    endfunction

    // Applies one accepted item to the shadow state and returns its result.
    function automatic term_status_t predict_status(input kind_t k,
                                                    input logic [CODE_W-1:0] code,
                                                    input logic [COLOR_W-1:0] color,
                                                    input logic [INDEX_W-1:0] idx);
        term_status_t st;
        st = '0;
        case (k)
            KIND_WRITE: st.scrolled = shadow_put_char(code);
            KIND_RAINBOW:
            begin
                shadow_color = {shadow_color[7:4] + 4'd1, shadow_color[3:0] + 4'd1};
                st.scrolled = shadow_put_char(code);
            end
            KIND_SET_COLOR: shadow_color = color;
            default:
            begin
                if (idx < GRID_CELLS)
                    st.cell_value = shadow_cells[idx];
            end
        endcase
        st.cursor_row = shadow_row[ROW_OUT_W-1:0];
        st.cursor_col = shadow_col[COL_OUT_W-1:0];
        st.color_now  = shadow_color;
        return st;
    endfunction

    // Mismatch reporting.

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
    endtask

    // Request driver. Valid stays high after an accepted item, so that a
    // following item never lowers and raises it within one time step.
    task automatic send_item(input kind_t k, input logic [CODE_W-1:0] code,
                             input logic [COLOR_W-1:0] color,
                             input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= k;
        req_ch.char_code  <= code;
        req_ch.new_color  <= color;
        req_ch.cell_index <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_status.push_back(predict_status(k, code, color, idx));
        items_sent++;
    endtask

    // Unused fields carry random values so that their bits toggle too.
    task automatic write_char(input kind_t k, input logic [CODE_W-1:0] code);
        send_item(k, code, COLOR_W'($urandom_range(255)),
                  INDEX_W'($urandom_range(INDEX_MAX)));
    endtask

    task automatic set_color(input logic [COLOR_W-1:0] color);
        send_item(KIND_SET_COLOR, CODE_W'($urandom_range(255)), color,
                  INDEX_W'($urandom_range(INDEX_MAX)));
    endtask

    task automatic read_cell(input int unsigned idx);
        send_item(KIND_READ, CODE_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
                  INDEX_W'(idx));
    endtask

    // Receiver: stalls at random as the current phase asks.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        term_status_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected result", rsp_ch.cell_value, 0);
            end
            else
            begin
                want = pending_status.pop_front();
                if (rsp_ch.cell_value !== want.cell_value)
                    report_mismatch("cell_value", rsp_ch.cell_value, want.cell_value);
                if (rsp_ch.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", rsp_ch.cursor_row, want.cursor_row);
                if (rsp_ch.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", rsp_ch.cursor_col, want.cursor_col);
                if (rsp_ch.color_now !== want.color_now)
                    report_mismatch("color_now", rsp_ch.color_now, want.color_now);
                if (rsp_ch.scrolled !== want.scrolled)
                    report_mismatch("scrolled", rsp_ch.scrolled, want.scrolled);
            end
        end
    end

    // Directed tests.

    // The cleared screen, both ends of the grid and reads past its end.
    task automatic test_reset_contents();
        read_cell(0);
        read_cell(GRID_CELLS - 1);
        read_cell(GRID_CELLS);
        read_cell(INDEX_MAX);
        read_cell(11'h555);
    endtask

    // Lowest, highest and upper-half character codes are stored as is.
    task automatic test_character_codes();
        write_char(KIND_WRITE, 8'h00);
        write_char(KIND_WRITE, 8'hFF);
        write_char(KIND_WRITE, 8'h80);
        write_char(KIND_WRITE, 8'h41);
        read_cell(0);
        read_cell(1);
        read_cell(2);
    endtask

    // Color extremes, rainbow nibble wrap and a rainbow newline.
    task automatic test_color_and_rainbow();
        int unsigned at;
        set_color(8'hFF);
        at = shadow_row * GRID_COLS + shadow_col;
        write_char(KIND_RAINBOW, 8'h5A);
        read_cell(at);
        set_color(8'h0F);
        write_char(KIND_RAINBOW, NEWLINE_CODE);
        set_color(8'h00);
        at = shadow_row * GRID_COLS + shadow_col;
        write_char(KIND_WRITE, 8'h7E);
        read_cell(at);
    endtask

    // A plain newline moves to the start of the next row.
    task automatic test_newline();
        write_char(KIND_WRITE, NEWLINE_CODE);
        write_char(KIND_WRITE, 8'h33);
        read_cell(shadow_row * GRID_COLS);
        set_color(RESET_COLOR);
    endtask

    // Random traffic, mostly runs of text with read-back near the cursor.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct, input int count);
        int          target;
        int unsigned pick;
        int unsigned len;
        int unsigned row;
        logic [CODE_W-1:0] code;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // Run of text, long enough at times to wrap a row.
                len = $urandom_range(90, 1);
                repeat (len) begin
                    code = ($urandom_range(99) < 6) ? NEWLINE_CODE
                                                     : CODE_W'($urandom_range(255));
                    write_char(($urandom_range(99) < 15) ? KIND_RAINBOW : KIND_WRITE, code);
                end
            end
            else if (pick < 60) begin
                repeat ($urandom_range(4, 1))
                    write_char(KIND_WRITE, NEWLINE_CODE);
            end
            else if (pick < 70) begin
                set_color(COLOR_W'($urandom_range(255)));
            end
            else if (pick < 95) begin
                // Read-back, mostly of the rows the cursor just touched.
                repeat ($urandom_range(6, 1)) begin
                    len = $urandom_range(99);
                    if (len < 70) begin
                        row = shadow_row;
                        if (row > 0 && $urandom_range(1))
                            row = row - 1;
                        read_cell(row * GRID_COLS + $urandom_range(GRID_COLS - 1));
                    end
                    else if (len < 90) begin
                        read_cell($urandom_range(GRID_CELLS - 1));
                    end
                    else
                    begin
                        read_cell($urandom_range(INDEX_MAX, GRID_CELLS));
                    end
                end
            end
            else
            begin
                send_item(kind_t'($urandom_range(3)), CODE_W'($urandom_range(255)),
                          COLOR_W'($urandom_range(255)), INDEX_W'($urandom_range(INDEX_MAX)));
            end
        end
    endtask

    // Run limit, far above the slowest correct run with every item scrolling.
    initial
    begin
        #(120_000_000);
        $display("text_mode_terminal_writer_unit_tb: FAIL");
        $finish;
    end

    // Test sequence.
    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= '0;
        req_ch.char_code  <= '0;
        req_ch.new_color  <= '0;
        req_ch.cell_index <= '0;
        reset_shadow();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_character_codes();
        test_color_and_rainbow();
        test_newline();

        test_random_traffic(0, 0, 260);
        test_random_traffic(55, 0, 260);
        test_random_traffic(0, 55, 260);
        test_random_traffic(14, 14, 260);

        // Let every outstanding result arrive and let the clock run on before the verdict.
        req_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("text_mode_terminal_writer_unit_tb: PASS");
        else
            $display("text_mode_terminal_writer_unit_tb: FAIL");
        $finish;
    end

endmodule
